// ----- rtl/core/mhpq_pkg.sv -----
// mhpq_pkg: shared types, sizes and codes for the min-heap priority queue
// no dependencies; imported by the top level (the store RAM user), the checker and the bench

package mhpq_pkg;

    // heap geometry
    localparam int HEAP_DEPTH = 16;
    localparam int IDX_W      = $clog2(HEAP_DEPTH);
    localparam int CNT_W      = $clog2(HEAP_DEPTH + 1);
    localparam int KEY_W      = 32;

    // operation codes carried by the kind field
    localparam logic KIND_INSERT   = 1'b0;
    localparam logic KIND_DECREASE = 1'b1;

    // result status codes
    typedef enum logic [1:0] {
        STATUS_DONE      = 2'd0,
        STATUS_OVERFLOW  = 2'd1,
        STATUS_BAD_INDEX = 2'd2
    } status_t;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_WRITE,
        ST_DONE
    } state_t;

    // parent position in the implicit tree, (i-1)/2
    function automatic logic [IDX_W-1:0] parent_of(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] dec;
        dec = idx - IDX_W'(1);
        return dec >> 1;
    endfunction

endpackage

// ----- rtl/core/mhpq_ram.sv -----
// mhpq_ram: generic single-write, single-read synchronous RAM
// registered read data; no package dependency

module mhpq_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/core/min_heap_priority_queue.sv -----
// min_heap_priority_queue: binary min-heap of signed keys with insert and decrease-key
// depends on mhpq_pkg and mhpq_ram

// The heap lives in a 16-entry synchronous RAM. Each transaction either inserts a key at
// the end of the heap or overwrites the entry at slot_index, then sifts that key up one
// level per cycle: the parent is read in the cycle before its compare, compared against
// the moving key, and moved down into the hole when it is larger. An item passes through
// accept, one parent compare per level climbed plus the compare that stops the climb when
// the key settles below the root, the final write and the result load; that is at most 4
// compares for 16 entries. Refused items (insert into a full heap, decrease-key at an
// index not in the heap) go from accept straight to the result load and leave the heap
// untouched. Every item returns exactly one result with the root key, the entry count and
// a status; the result load of an item waits while the previous result is still held at
// the output. The root is also kept in a register, so an empty heap reports zero; no
// clearing pass is needed after reset. A new item is accepted while the previous result
// still waits at the output.

module min_heap_priority_queue (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         kind,
    input  logic signed [mhpq_pkg::KEY_W-1:0] key_value,
    input  logic [mhpq_pkg::IDX_W-1:0]   slot_index,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [mhpq_pkg::KEY_W-1:0] min_key,
    output logic [mhpq_pkg::CNT_W-1:0]   entry_count,
    output logic [1:0]                   status
);

    import mhpq_pkg::*;

    state_t                   state_reg, state_next;
    logic [IDX_W-1:0]         pos_reg, pos_next;
    logic signed [KEY_W-1:0]  key_reg, key_next;
    logic [CNT_W-1:0]         fill_reg, fill_next;
    logic signed [KEY_W-1:0]  root_reg, root_next;
    status_t                  status_reg, status_next;

    logic                     out_valid_reg, out_valid_next;
    logic signed [KEY_W-1:0]  min_key_reg, min_key_next;
    logic [CNT_W-1:0]         count_out_reg, count_out_next;
    status_t                  status_out_reg, status_out_next;

    logic                     ram_we;
    logic [IDX_W-1:0]         ram_waddr;
    logic [KEY_W-1:0]         ram_wdata;
    logic [IDX_W-1:0]         ram_raddr;
    logic [KEY_W-1:0]         ram_rdata;

    logic                     in_accept;
    logic [IDX_W-1:0]         start_pos;
    logic [IDX_W-1:0]         pos_parent;

    // heap store
    mhpq_ram #(
        .DEPTH (HEAP_DEPTH),
        .WIDTH (KEY_W)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_ready   = (state_reg == ST_IDLE);
    assign in_accept  = in_valid && in_ready;
    assign pos_parent = parent_of(pos_reg);
    assign start_pos  = (kind == KIND_INSERT) ? fill_reg[IDX_W-1:0] : slot_index;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            fill_reg       <= '0;
            root_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            root_reg       <= root_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pos_reg        <= pos_next;
        key_reg        <= key_next;
        status_reg     <= status_next;
        min_key_reg    <= min_key_next;
        count_out_reg  <= count_out_next;
        status_out_reg <= status_out_next;
    end

    // sift-up sequencer
    always_comb
    begin
        state_next      = state_reg;
        pos_next        = pos_reg;
        key_next        = key_reg;
        fill_next       = fill_reg;
        root_next       = root_reg;
        status_next     = status_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        min_key_next    = min_key_reg;
        count_out_next  = count_out_reg;
        status_out_next = status_out_reg;
        ram_we          = 1'b0;
        ram_waddr       = pos_reg;
        ram_wdata       = key_reg;
        ram_raddr       = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    key_next    = key_value;
                    pos_next    = start_pos;
                    status_next = STATUS_DONE;
                    if (kind == KIND_INSERT && fill_reg >= CNT_W'(HEAP_DEPTH))
                    begin
                        status_next = STATUS_OVERFLOW;
                        state_next  = ST_DONE;
                    end
                    else if (kind == KIND_DECREASE && CNT_W'(slot_index) >= fill_reg)
                    begin
                        status_next = STATUS_BAD_INDEX;
                        state_next  = ST_DONE;
                    end
                    else
                    begin
                        if (kind == KIND_INSERT)
                        begin
                            fill_next = fill_reg + CNT_W'(1);
                        end
                        if (start_pos == '0)
                        begin
                            state_next = ST_WRITE;
                        end
                        else
                        begin
                            ram_raddr  = parent_of(start_pos);
                            state_next = ST_CMP;
                        end
                    end
                end
            end

            ST_CMP:
            begin
                // parent larger: move it down into the hole and climb
                if ($signed(ram_rdata) > key_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = pos_reg;
                    ram_wdata = ram_rdata;
                    pos_next  = pos_parent;
                    if (pos_parent == '0)
                    begin
                        state_next = ST_WRITE;
                    end
                    else
                    begin
                        ram_raddr  = parent_of(pos_parent);
                        state_next = ST_CMP;
                    end
                end
                else
                begin
                    state_next = ST_WRITE;
                end
            end

            ST_WRITE:
            begin
                // drop the moving key into its final slot
                ram_we    = 1'b1;
                ram_waddr = pos_reg;
                ram_wdata = key_reg;
                if (pos_reg == '0)
                begin
                    root_next = key_reg;
                end
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                // load the result once the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    min_key_next    = root_reg;
                    count_out_next  = fill_reg;
                    status_out_next = status_reg;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid   = out_valid_reg;
    assign min_key     = min_key_reg;
    assign entry_count = count_out_reg;
    assign status      = status_out_reg;

endmodule

// ----- rtl/core/mhpq_checker.sv -----
// mhpq_checker: port-level checks for the min-heap priority queue
// depends on mhpq_pkg; bound to min_heap_priority_queue at the end of this file

module mhpq_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         out_valid,
    input  logic                         out_ready,
    input  logic signed [mhpq_pkg::KEY_W-1:0] min_key,
    input  logic [mhpq_pkg::CNT_W-1:0]   entry_count,
    input  logic [1:0]                   status
);

    import mhpq_pkg::*;

    // a stalled result transaction holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(min_key)
            && $stable(entry_count) && $stable(status))
    else $error("result changed while stalled");

    // entry count never exceeds the heap depth
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> entry_count <= CNT_W'(HEAP_DEPTH))
    else $error("entry count beyond heap depth");

    // overflow is reported only when the heap is full
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STATUS_OVERFLOW |-> entry_count == CNT_W'(HEAP_DEPTH))
    else $error("overflow with room left");

    // an empty heap always reports zero as its minimum
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && entry_count == '0 |-> min_key == '0)
    else $error("empty heap with nonzero minimum");

    // status code is one of the defined values
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status == STATUS_DONE || status == STATUS_OVERFLOW
            || status == STATUS_BAD_INDEX)
    else $error("undefined status code");

endmodule

bind min_heap_priority_queue mhpq_checker u_mhpq_checker (.*);

// ----- bench/tb_min_heap_priority_queue.sv -----
// tb_min_heap_priority_queue: self-checking bench for the min-heap priority queue
// depends on mhpq_pkg and the min_heap_priority_queue RTL; a shadow heap predicts every result
// directed corner items come first, then random insert and decrease-key traffic

`timescale 1ns / 1ps

module tb_min_heap_priority_queue;
    import mhpq_pkg::*;

    localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;
    localparam int RANDOM_ITEMS = 450;
    localparam int QUIET_TAIL   = 60;
    localparam int LONG_HOLD    = 250;

    // one predicted result
    typedef struct {
        logic signed [KEY_W-1:0] root;
        logic [CNT_W-1:0]        count;
        status_t                 st;
    } heap_result_t;

    // shadow heap plus queue of predicted results
    class heap_scoreboard;
        logic signed [KEY_W-1:0] shadow_heap [HEAP_DEPTH];
        int unsigned             shadow_fill;
        heap_result_t            expected_q [$];
        int unsigned             mismatches;
        int unsigned             checked;
        int unsigned             n_insert;
        int unsigned             n_overflow;
        int unsigned             n_decrease;
        int unsigned             n_bad_index;

        function new();
            foreach (shadow_heap[i])
                shadow_heap[i] = '0;
            shadow_fill = 0;
            mismatches  = 0;
            checked     = 0;
            n_insert    = 0;
            n_overflow  = 0;
            n_decrease  = 0;
            n_bad_index = 0;
        endfunction

        // swap upward while the parent is strictly larger
        function void climb(int unsigned pos);
            int unsigned up;
            logic signed [KEY_W-1:0] t;
            while (pos != 0) begin
                up = (pos - 1) / 2;
                if (!(shadow_heap[up] > shadow_heap[pos]))
                    break;
                t = shadow_heap[up];
                shadow_heap[up] = shadow_heap[pos];
                shadow_heap[pos] = t;
                pos = up;
            end
        endfunction

        // apply an accepted transaction and queue its result
        function void note_input(logic k, logic signed [KEY_W-1:0] key, logic [IDX_W-1:0] slot);
            heap_result_t r;
            status_t st;
            st = STATUS_DONE;
            if (k == KIND_INSERT) begin
                n_insert++;
                if (shadow_fill >= HEAP_DEPTH) begin
                    st = STATUS_OVERFLOW;
                    n_overflow++;
                end
                else begin
                    shadow_heap[shadow_fill] = key;
                    shadow_fill++;
                    climb(shadow_fill - 1);
                end
            end
            else begin
                n_decrease++;
                if (slot >= shadow_fill) begin
                    st = STATUS_BAD_INDEX;
                    n_bad_index++;
                end
                else begin
                    shadow_heap[slot] = key;
                    climb(slot);
                end
            end
            r.root  = shadow_heap[0];
            r.count = CNT_W'(shadow_fill);
            r.st    = st;
            expected_q.push_back(r);
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            if (mismatches <= 40)
                $display("MISMATCH at result %0d: %s", checked, msg);
        endtask

        // compare one result transaction with the oldest prediction
        task check_result(logic signed [KEY_W-1:0] got_root, logic [CNT_W-1:0] got_cnt,
                          logic [1:0] got_st);
            heap_result_t e;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result, min_key %0d", got_root));
                return;
            end
            e = expected_q.pop_front();
            checked++;
            if (got_root !== e.root)
                report_mismatch($sformatf("min_key got %0d expected %0d", got_root, e.root));
            if (got_cnt !== e.count)
                report_mismatch($sformatf("entry_count got %0d expected %0d", got_cnt, e.count));
            if (got_st !== e.st)
                report_mismatch($sformatf("status got %0d expected %0d", got_st, e.st));
        endtask

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic                    kind = KIND_INSERT;
    logic signed [KEY_W-1:0] key_value = '0;
    logic [IDX_W-1:0]        slot_index = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic signed [KEY_W-1:0] min_key;
    logic [CNT_W-1:0]        entry_count;
    logic [1:0]              status;

    bit sender_gaps = 1'b1;
    bit sink_stalls = 1'b1;
    bit hold_req    = 1'b0;

    heap_scoreboard sb = new();

    min_heap_priority_queue dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .key_value   (key_value),
        .slot_index  (slot_index),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .min_key     (min_key),
        .entry_count (entry_count),
        .status      (status)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // reset at start, released once
    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    // run limit
    initial
    begin
        #3_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(min_key, entry_count, status);
    end

    // receiver: random stall bursts, one long hold on request
    initial
    begin
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_req) begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (sink_stalls && $urandom_range(0, 2) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
            else begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
        end
    end

    // offer one input transaction and wait for its handshake
    task send_item(input logic k, input logic signed [KEY_W-1:0] key,
                   input logic [IDX_W-1:0] slot);
        int gap;
        gap = 0;
        if (sender_gaps && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 9);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        kind       <= k;
        key_value  <= key;
        slot_index <= slot;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_input(k, key, slot);
    endtask

    // keys weighted toward the extremes and near zero
    function automatic logic signed [KEY_W-1:0] pick_key();
        case ($urandom_range(0, 7))
            0: return KEY_MIN;
            1: return KEY_MAX;
            2: return KEY_W'($signed($urandom_range(0, 64)) - 32);
            default: return $urandom();
        endcase
    endfunction

    initial
    begin
        int guard;
        logic k;
        wait (rst_n === 1'b1);
        @(posedge clk);

        // empty heap: decrease-key refused, root reads zero
        send_item(KIND_DECREASE, 32'sd5, 4'd0);
        send_item(KIND_DECREASE, -32'sd1, 4'd15);
        // inserts at the key extremes, minimum climbs to the root
        send_item(KIND_INSERT, KEY_MAX, 4'd9);
        send_item(KIND_INSERT, 32'sd100, 4'd0);
        send_item(KIND_INSERT, KEY_MIN, 4'd15);
        send_item(KIND_INSERT, 32'sd0, 4'd3);
        send_item(KIND_INSERT, -32'sd1, 4'd7);
        // equal to parent: no swap
        send_item(KIND_DECREASE, KEY_MIN, 4'd1);
        // value not smaller: written in place, no sift-down
        send_item(KIND_DECREASE, KEY_MAX, 4'd4);
        // index just past the last entry
        send_item(KIND_DECREASE, 32'sd7, 4'd5);
        // fill the heap
        for (int i = 1; i <= 11; i++)
            send_item(KIND_INSERT, -32'sd1000 * i, IDX_W'($urandom_range(0, 15)));
        // full heap refuses an insert
        send_item(KIND_INSERT, -32'sd2, 4'd0);
        // deepest leaf climbs to just under the root
        send_item(KIND_DECREASE, KEY_MIN + 1, 4'd15);
        send_item(KIND_DECREASE, KEY_MAX, 4'd0);
        send_item(KIND_DECREASE, KEY_MIN, 4'd10);

        // random traffic, long receiver hold at the start of it
        hold_req = 1'b1;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == RANDOM_ITEMS - QUIET_TAIL) begin
                sender_gaps = 1'b0;
                sink_stalls = 1'b0;
            end
            k = ($urandom_range(0, 3) == 0) ? KIND_INSERT : KIND_DECREASE;
            send_item(k, pick_key(), IDX_W'($urandom_range(0, 15)));
        end
        in_valid <= 1'b0;

        // drain outstanding results
        guard = 0;
        while (sb.pending() != 0 && guard < 20000) begin
            @(posedge clk);
            guard++;
        end
        repeat (20) @(posedge clk);
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));

        $display("covered %0d inserts (%0d refused on a full heap), %0d decrease-keys (%0d out of range)",
                 sb.n_insert, sb.n_overflow, sb.n_decrease, sb.n_bad_index);
        $display("%0d results checked, %0d mismatches", sb.checked, sb.mismatches);
        if (sb.mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/mhpq_pkg.sv
rtl/core/mhpq_ram.sv
rtl/core/min_heap_priority_queue.sv
rtl/core/mhpq_checker.sv
bench/tb_min_heap_priority_queue.sv
